FILE: hdl/matrix3x3_inverse_macros.svh
// ---------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shared property wrappers for the inverse datapath checks
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// same-cycle implication, disabled during reset
`define M3I_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define M3I_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/m3i_pkg.sv
// ---------------------------------------------------------------------------
// m3i_pkg
// Shared constants and types for the 3x3 matrix inverse
// ---------------------------------------------------------------------------
package m3i_pkg;

  // matrix elements per transfer
  localparam int unsigned NUM_ELEMS = 9;

  // operand element indexes (a, b, c, d) of each adjugate term a*b - c*d
  localparam int unsigned COF_IDX [NUM_ELEMS][4] = '{
    '{4, 8, 5, 7},
    '{7, 2, 1, 8},
    '{1, 5, 4, 2},
    '{6, 5, 3, 8},
    '{0, 8, 2, 6},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{6, 1, 0, 7},
    '{0, 4, 1, 3}
  };

  // per-lane status handed to the merge stage
  typedef struct packed {
    logic saturated;
    logic singular;
  } flags_t;

endpackage

FILE: hdl/m3i_cofactor_lane.sv
// ---------------------------------------------------------------------------
// m3i_cofactor_lane
// One adjugate term a*b - c*d, two pipeline stages
// ---------------------------------------------------------------------------
module m3i_cofactor_lane #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [ELEM_WIDTH-1:0]  a,
  input  logic signed [ELEM_WIDTH-1:0]  b,
  input  logic signed [ELEM_WIDTH-1:0]  c,
  input  logic signed [ELEM_WIDTH-1:0]  d,
  output logic signed [2*ELEM_WIDTH:0]  adj
);

  localparam int PW = 2 * ELEM_WIDTH;

  logic signed [PW-1:0] p_ab;
  logic signed [PW-1:0] p_cd;

  // both products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_ab <= a * b;
      p_cd <= c * d;
    end
  end

  // difference, one extra bit
  always_ff @(posedge clk) begin
    if (en[1]) begin
      adj <= (PW+1)'(p_ab) - (PW+1)'(p_cd);
    end
  end

endmodule

FILE: hdl/m3i_det_unit.sv
// ---------------------------------------------------------------------------
// m3i_det_unit
// Determinant from first row and its cofactors, three pipeline stages
// ---------------------------------------------------------------------------
module m3i_det_unit #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                            clk,
  input  logic [2:0]                      en,
  input  logic signed [ELEM_WIDTH-1:0]    m0,
  input  logic signed [ELEM_WIDTH-1:0]    m1,
  input  logic signed [ELEM_WIDTH-1:0]    m2,
  input  logic signed [2*ELEM_WIDTH:0]    a0,
  input  logic signed [2*ELEM_WIDTH:0]    a3,
  input  logic signed [2*ELEM_WIDTH:0]    a6,
  output logic signed [3*ELEM_WIDTH+1:0]  det
);

  localparam int W  = ELEM_WIDTH;
  localparam int PW = 2 * W + 1;
  localparam int DW = 3 * W + 2;

  logic signed [PW-1:0] p_lo [3];
  logic signed [PW-1:0] p_hi [3];
  logic signed [DW-1:0] term [3];
  logic signed [W-1:0]  mv   [3];
  logic signed [PW-1:0] av   [3];

  assign mv[0] = m0;
  assign mv[1] = m1;
  assign mv[2] = m2;
  assign av[0] = a0;
  assign av[1] = a3;
  assign av[2] = a6;

  // split each cofactor into an unsigned low half and a signed high part
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        p_lo[i] <= PW'(mv[i] * $signed({1'b0, av[i][W-1:0]}));
        p_hi[i] <= PW'(mv[i] * $signed(av[i][PW-1:W]));
      end
    end
  end

  // recombine the halves of each term
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= (DW'(p_hi[i]) <<< W) + DW'(p_lo[i]);
      end
    end
  end

  // three-term sum
  always_ff @(posedge clk) begin
    if (en[2]) begin
      det <= term[0] + term[1] + term[2];
    end
  end

endmodule

FILE: hdl/m3i_div_lane.sv
// ---------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divide of one cofactor by the determinant
// ---------------------------------------------------------------------------
module m3i_div_lane #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic [ELEM_WIDTH+2:0]           en,
  input  logic signed [2*ELEM_WIDTH:0]    adj,
  input  logic signed [3*ELEM_WIDTH+1:0]  det,
  output logic [ELEM_WIDTH-1:0]           elem,
  output m3i_pkg::flags_t                 flags
);

  localparam int W   = ELEM_WIDTH;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = 3 * W + 2;
  localparam int NW  = 2 * W + 2 * FRAC_BITS;
  localparam int DSW = DW + W;
  localparam int CW  = ((NW > DSW) ? NW : DSW) + 1;

  logic [AW-1:0] a_abs;
  logic [DW-1:0] d_abs;

  logic [CW-1:0] nmag_p;
  logic [CW-1:0] dmag_p;
  logic          neg_p;
  logic          zero_p;

  logic [CW-1:0] rem  [0:W];
  logic [CW-1:0] dmag [0:W];
  logic [W-1:0]  quo  [0:W];
  logic          neg  [0:W];
  logic          zero [0:W];
  logic          ovf  [0:W];

  logic [W-1:0]  lim;
  logic          clip;
  logic [W-1:0]  mag;

  // magnitudes and signs
  assign a_abs = adj[AW-1] ? AW'(-adj) : AW'(adj);
  assign d_abs = det[DW-1] ? DW'(-det) : DW'(det);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nmag_p <= CW'(a_abs) << (2 * FRAC_BITS);
      dmag_p <= CW'(d_abs);
      neg_p  <= adj[AW-1] ^ det[DW-1];
      zero_p <= (det == '0);
    end
  end

  // quotient of 2^W or more saturates outright
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0]  <= nmag_p;
      dmag[0] <= dmag_p;
      quo[0]  <= '0;
      neg[0]  <= neg_p;
      zero[0] <= zero_p;
      ovf[0]  <= (nmag_p >= (dmag_p << W));
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j <= W; j++) begin : g_bit
    logic [CW-1:0] dsh;
    logic          ge;
    logic [W-1:0]  qbit;

    assign dsh  = dmag[j-1] << (W - j);
    assign ge   = (rem[j-1] >= dsh);
    assign qbit = W'(ge) << (W - j);

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        rem[j]  <= ge ? (rem[j-1] - dsh) : rem[j-1];
        dmag[j] <= dmag[j-1];
        quo[j]  <= quo[j-1] | qbit;
        neg[j]  <= neg[j-1];
        zero[j] <= zero[j-1];
        ovf[j]  <= ovf[j-1];
      end
    end
  end

  // saturate to the element range and apply the sign
  assign lim  = {neg[W], {(W-1){~neg[W]}}};
  assign clip = ovf[W] || (quo[W] > lim);
  assign mag  = clip ? lim : quo[W];

  always_ff @(posedge clk) begin
    if (en[W+2]) begin
      if (zero[W]) begin
        elem            <= '0;
        flags.saturated <= 1'b0;
        flags.singular  <= 1'b1;
      end else begin
        elem            <= neg[W] ? W'(-mag) : mag;
        flags.saturated <= clip;
        flags.singular  <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/matrix3x3_inverse.sv
// ---------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 fixed-point matrix inverse by adjugate and pipelined division
// ---------------------------------------------------------------------------
//  channel   dir  payload
//  s_*       in   tdata: m11 m12 m13 m21 m22 m23 m31 m32 m33
//  m_*       out  tdata: r11 .. r33; tuser: singular, saturated
//
//  One matrix per cycle sustained while m_tready is high; the pipeline
//  depth is set by the one-bit-per-stage divide lanes.
//  Every stage holds its own valid bit; a stage loads when it is empty
//  or the next stage moves, so bubbles collapse under output stalls.
//  Reset clears only the valid bits.
// ---------------------------------------------------------------------------
`include "matrix3x3_inverse_macros.svh"

module matrix3x3_inverse #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33
  output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular, saturated
  output logic [1:0]             m_tuser
);

  localparam int W   = ELEM_WIDTH;
  localparam int NE  = m3i_pkg::NUM_ELEMS;
  localparam int TDW = ((NE * W + 7) / 8) * 8;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = 3 * W + 2;
  localparam int NS  = W + 9;
  localparam int DIV0 = 5;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [AW-1:0] adj   [NE];
  logic signed [AW-1:0] adj_d [3][NE];
  logic signed [W-1:0]  row_d [2][3];
  logic signed [DW-1:0] det;
  logic [W-1:0]         elem  [NE];
  logic [NE*W-1:0]      elem_flat;
  m3i_pkg::flags_t      flags [NE];
  logic [NE-1:0]        sing_v;
  logic [NE-1:0]        sat_v;

  // stage advance chain
  assign en[NS-1] = !vld[NS-1] || m_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign s_tready = en[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // cofactor lanes
  for (genvar i = 0; i < NE; i++) begin : g_cof
    m3i_cofactor_lane #(.ELEM_WIDTH(W)) u_cof (
      .clk (clk),
      .en  (en[1:0]),
      .a   (s_tdata[m3i_pkg::COF_IDX[i][0]*W +: W]),
      .b   (s_tdata[m3i_pkg::COF_IDX[i][1]*W +: W]),
      .c   (s_tdata[m3i_pkg::COF_IDX[i][2]*W +: W]),
      .d   (s_tdata[m3i_pkg::COF_IDX[i][3]*W +: W]),
      .adj (adj[i])
    );
  end

  // first row delayed to meet the cofactors
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) row_d[0][c] <= s_tdata[c*W +: W];
    end
    if (en[1]) begin
      row_d[1] <= row_d[0];
    end
  end

  m3i_det_unit #(.ELEM_WIDTH(W)) u_det (
    .clk (clk),
    .en  (en[4:2]),
    .m0  (row_d[1][0]),
    .m1  (row_d[1][1]),
    .m2  (row_d[1][2]),
    .a0  (adj[0]),
    .a3  (adj[3]),
    .a6  (adj[6]),
    .det (det)
  );

  // cofactors delayed to meet the determinant
  always_ff @(posedge clk) begin
    if (en[2]) adj_d[0] <= adj;
    if (en[3]) adj_d[1] <= adj_d[0];
    if (en[4]) adj_d[2] <= adj_d[1];
  end

  // divide lanes
  for (genvar i = 0; i < NE; i++) begin : g_div
    m3i_div_lane #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en[DIV0+W+2:DIV0]),
      .adj   (adj_d[2][i]),
      .det   (det),
      .elem  (elem[i]),
      .flags (flags[i])
    );
    assign elem_flat[i*W +: W] = elem[i];
    assign sing_v[i] = flags[i].singular;
    assign sat_v[i]  = flags[i].saturated;
  end

  // merge lanes into the output register, pad bits zero
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      m_tdata    <= TDW'(elem_flat);
      m_tuser[0] <= &sing_v;
      m_tuser[1] <= |sat_v;
    end
  end

  assign m_tvalid = vld[NS-1];

  // checks
  `M3I_ASSERT_IMPL(a_sing_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0, "singular result not zero")
  `M3I_ASSERT_IMPL(a_sing_nosat, clk, rst, m_tvalid && m_tuser[0], !m_tuser[1], "singular result flagged saturated")
  `M3I_ASSERT_IMPL(a_bubble_ready, clk, rst, !vld[0], s_tready, "empty entry stage refuses input")
  `M3I_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "stalled result dropped")

endmodule
